// ===== rtl/pfb_pkg.sv =====
// ----------------------------------------------------------------------------
// pfb_pkg
// Shared types, constants and the fixed coefficient table of the polyphase
// FIR branch.
// ----------------------------------------------------------------------------
package pfb_pkg;

    localparam int CoefDepth = 31;
    localparam int CoefIdxW  = 8;
    localparam int CoefW     = 17;
    localparam int SampleW   = 16;
    localparam int AccW      = 32;   // result only needs sum bits 31..16

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } pfb_state_t;

    // Sequencer to datapath control
    typedef struct packed {
        logic wr_en;     // write new sample into the ring
        logic rd_en;     // issue one ring read / one MAC step
        logic rd_ok;     // ring entry has been written since reset
        logic rd_last;   // final term of this word
        logic acc_clr;   // start of a new word
    } pfb_ctl_t;

    function automatic logic signed [CoefW-1:0] coef_at(input logic [CoefIdxW-1:0] idx);
        logic signed [CoefW-1:0] c;
        begin
            case (idx)
                8'd0:    c = -17'sd145;
                8'd1:    c = -17'sd12;
                8'd2:    c = 17'sd193;
                8'd3:    c = -17'sd414;
                8'd4:    c = 17'sd504;
                8'd5:    c = -17'sd272;
                8'd6:    c = -17'sd359;
                8'd7:    c = 17'sd1229;
                8'd8:    c = -17'sd1913;
                8'd9:    c = 17'sd1831;
                8'd10:   c = -17'sd496;
                8'd11:   c = -17'sd2220;
                8'd12:   c = 17'sd5923;
                8'd13:   c = -17'sd9747;
                8'd14:   c = 17'sd12631;
                8'd15:   c = 17'sd51832;
                8'd16:   c = 17'sd12631;
                8'd17:   c = -17'sd9747;
                8'd18:   c = 17'sd5923;
                8'd19:   c = -17'sd2220;
                8'd20:   c = -17'sd496;
                8'd21:   c = 17'sd1831;
                8'd22:   c = -17'sd1913;
                8'd23:   c = 17'sd1229;
                8'd24:   c = -17'sd359;
                8'd25:   c = -17'sd272;
                8'd26:   c = 17'sd504;
                8'd27:   c = -17'sd414;
                8'd28:   c = 17'sd193;
                8'd29:   c = -17'sd12;
                8'd30:   c = -17'sd145;
                default: c = '0;  // taps beyond the table
            endcase
            return c;
        end
    endfunction

endpackage

// ===== rtl/pfb_mac.sv =====
// ----------------------------------------------------------------------------
// pfb_mac
// Sample ring memory and the multiply-accumulate pipeline: registered read,
// coefficient lookup and multiply, then accumulate.
// ----------------------------------------------------------------------------
module pfb_mac
    import pfb_pkg::*;
#(
    parameter int TAPS = 31,
    parameter int AW   = $clog2(TAPS)
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  pfb_ctl_t                  ctl,
    input  logic [AW-1:0]             wr_addr,
    input  logic signed [SampleW-1:0] wr_data,
    input  logic [AW-1:0]             rd_addr,
    input  logic [AW-1:0]             rd_tap,
    output logic                      done,
    output logic [AccW-1:0]           acc
);

    logic signed [SampleW-1:0] ring_mem [TAPS];
    logic signed [SampleW-1:0] rdata_reg;

    logic          s1_valid_reg;
    logic          s1_ok_reg;
    logic          s1_last_reg;
    logic [AW-1:0] s1_tap_reg;

    logic                 s2_valid_reg;
    logic                 s2_last_reg;
    logic [AccW-1:0]      prod_reg;
    logic [AccW-1:0]      prod_next;
    logic [AccW-1:0]      acc_reg;

    logic signed [CoefW-1:0]   coef;
    logic signed [SampleW-1:0] smp;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            ring_mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= ring_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= ctl.rd_en;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_ok_reg   <= ctl.rd_ok;
        s1_last_reg <= ctl.rd_last;
        s1_tap_reg  <= rd_tap;
        s2_last_reg <= s1_last_reg;
        prod_reg    <= prod_next;
    end

    // never-written ring entries read as zero
    always_comb
    begin
        coef      = coef_at(CoefIdxW'(s1_tap_reg));
        smp       = s1_ok_reg ? rdata_reg : '0;
        prod_next = AccW'(coef * smp);
    end

    // sum kept modulo 2^32: bits 31..16 are all the result uses
    always_ff @(posedge clk)
    begin
        if (ctl.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (s2_valid_reg)
        begin
            acc_reg <= acc_reg + prod_reg;
        end
    end

    assign done = s2_valid_reg && s2_last_reg;
    assign acc  = acc_reg;

endmodule

// ===== rtl/polyphase_fir_branch_top.sv =====
// ----------------------------------------------------------------------------
// polyphase_fir_branch_top
// One branch of a polyphase FIR filter with fixed coefficients.
// ----------------------------------------------------------------------------
// Input word: phase and sample_in, taken when in_valid is high and in_stall
// low. The sample goes into a TAPS-entry ring memory; then the sequencer
// reads the ring one entry per cycle, newest first, against coefficients
// phase, phase+2, ... and the MAC pipeline sums the products.
// Output word: sample_out = bits 31..16 of the sum (wraps, no saturation),
// held in an output register with out_valid until out_stall is low.
// Terms: N = ceil((TAPS - phase) / 2) per word. After the last read the
// MAC pipeline drains; out_valid rises when the sum is loaded into the
// output register, and the next input word is taken only after that load.
// The single ring read port limits the walk to one term per cycle.
// in_stall is high while a word is in work. A stalled output word holds;
// the next word may be computed meanwhile, and its result waits in the
// accumulator, with the sequencer in ST_DONE, until the output register frees.
// Reset: ring reads as all zeros (a fill count masks unwritten entries),
// write position zero, no output word pending.
// ----------------------------------------------------------------------------
module polyphase_fir_branch_top
    import pfb_pkg::*;
#(
    parameter int TAPS = 31
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      phase,
    input  logic signed [SampleW-1:0] sample_in,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [SampleW-1:0] sample_out
);

    localparam int AW = $clog2(TAPS);
    localparam int FW = $clog2(TAPS + 1);

    pfb_state_t state_reg;
    pfb_state_t state_next;

    logic [AW-1:0] wp_reg;
    logic [FW-1:0] fill_reg;
    logic [AW-1:0] rd_addr_reg;
    logic [AW-1:0] tap_reg;

    logic                      out_valid_reg;
    logic signed [SampleW-1:0] out_data_reg;

    logic       accept;
    logic       issue;
    logic       load_out;
    logic       last_term;
    logic       out_free;
    logic       done;
    logic [AccW-1:0] acc;
    pfb_ctl_t   ctl;

    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign last_term = ({1'b0, tap_reg} + (AW+1)'(2)) >= (AW+1)'(TAPS);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (last_term)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_stall = 1'b1;
        issue    = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE:  in_stall = 1'b0;
            ST_RUN:   issue    = 1'b1;
            ST_DRAIN: issue    = 1'b0;
            ST_DONE:  load_out = out_free;
            default:  in_stall = 1'b1;
        endcase
    end

    always_comb
    begin
        ctl.wr_en   = accept;
        ctl.acc_clr = accept;
        ctl.rd_en   = issue;
        ctl.rd_ok   = FW'(rd_addr_reg) < fill_reg;
        ctl.rd_last = last_term;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                wp_reg <= (wp_reg == AW'(TAPS - 1)) ? '0 : wp_reg + 1'b1;
                if (fill_reg != FW'(TAPS))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // read walk: newest sample first, stepping back with wrap
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_addr_reg <= wp_reg;
            tap_reg     <= AW'(phase);
        end
        else if (issue)
        begin
            rd_addr_reg <= (rd_addr_reg == '0) ? AW'(TAPS - 1) : rd_addr_reg - 1'b1;
            tap_reg     <= tap_reg + AW'(2);
        end
        if (load_out)
        begin
            out_data_reg <= acc[2*SampleW-1:SampleW];
        end
    end

    pfb_mac #(
        .TAPS (TAPS),
        .AW   (AW)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .wr_addr (wp_reg),
        .wr_data (sample_in),
        .rd_addr (rd_addr_reg),
        .rd_tap  (tap_reg),
        .done    (done),
        .acc     (acc)
    );

    assign out_valid  = out_valid_reg;
    assign sample_out = out_data_reg;

endmodule
